/* hw/rtl/assert_macros.svh */
// assertion macros shared by the eeprom rtl
// no dependencies; included by the files that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, switched off while reset is held
`define EEP_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: property failed");

// property checked on every rising edge, reset included
`define EEP_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("%m: property failed");

`endif

/* hw/rtl/eep_pkg.sv */
// types and constants for the serial eeprom bit protocol block
// no dependencies; used by every module under hw/rtl
package eep_pkg;

  // store geometry
  localparam int unsigned BLOCK_COUNT = 1024;
  localparam int unsigned IDX_W       = $clog2(BLOCK_COUNT);
  localparam int unsigned WORD_W      = 64;

  // command and address decode
  localparam logic [7:0]  CMD_READ_BIT = 8'h40;
  localparam logic [15:0] DMA_LARGE_A  = 16'h0011;
  localparam logic [15:0] DMA_LARGE_B  = 16'h0051;

  // bit counter landmarks
  localparam logic [6:0] CNT_ADDR_SMALL = 7'd9;
  localparam logic [6:0] CNT_ADDR_LARGE = 7'h11;
  localparam logic [6:0] CNT_RDPRE_END  = 7'd4;
  localparam logic [6:0] CNT_BLOCK      = 7'h40;
  localparam logic [6:0] CNT_STOP       = 7'h41;
  localparam logic [3:0] BYTE_IDX_MAX   = 4'd8;

  // protocol phase, one-hot
  typedef enum logic [4:0] {
    MODE_IDLE   = 5'b00001,
    MODE_ADDR   = 5'b00010,
    MODE_RDPRE  = 5'b00100,
    MODE_RDDATA = 5'b01000,
    MODE_WRDATA = 5'b10000
  } mode_e;

  // input item: one bus access
  typedef struct packed {
    logic        op;
    logic        write_bit;
    logic [15:0] dma_count;
  } in_item_t;

  // result item
  typedef struct packed {
    logic read_bit;
    logic block_written;
    logic in_use;
    logic large_size;
  } out_item_t;

  // store access from the sequencer
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  idx;
    logic [WORD_W-1:0] wdata;
  } store_req_t;

endpackage

/* hw/rtl/serial_eeprom_bit_protocol.sv */
// serial eeprom bit protocol: one bus bit access per item, one result per item
// throughput: one item per cycle while the buffer's skid entry is free; the
// store's registered read port follows the block address, so read data is
// ready before the first data bit is asked for
// reset: phase, counters and flags clear at once; the block store is not cleared
// and needs no clearing pass, an unwritten block reads back undefined
module serial_eeprom_bit_protocol (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  eep_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output eep_pkg::out_item_t out_item_o
);

  logic                       acc;
  eep_pkg::store_req_t        store_req;
  logic [eep_pkg::WORD_W-1:0] rdata;
  eep_pkg::out_item_t         res;

  assign acc = in_valid_i && in_ready_o;

  // protocol sequencer
  eep_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .item_i      (in_item_i),
    .rdata_i     (rdata),
    .store_req_o (store_req),
    .res_o       (res)
  );

  // 64-bit block store
  eep_store u_store (
    .clk_i   (clk_i),
    .req_i   (store_req),
    .rdata_o (rdata)
  );

  // result buffer
  eep_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (acc),
    .in_ready_o  (in_ready_o),
    .in_item_i   (res),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

/* hw/rtl/eep_store.sv */
// block store: BLOCK_COUNT words of 64 bits, one write and one registered read port
// depends on eep_pkg
module eep_store (
  input  logic                         clk_i,
  input  eep_pkg::store_req_t          req_i,
  output logic [eep_pkg::WORD_W-1:0]   rdata_o
);

  logic [eep_pkg::WORD_W-1:0] mem [eep_pkg::BLOCK_COUNT];
  logic [eep_pkg::WORD_W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.idx] <= req_i.wdata;
    end
  end

  // read port, registered, follows the current block address
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[req_i.idx];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/eep_ctrl.sv */
// protocol sequencer: phase, counters, shift bytes and store access
// depends on eep_pkg and assert_macros.svh
`include "assert_macros.svh"

module eep_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        acc_i,
  input  eep_pkg::in_item_t           item_i,
  input  logic [eep_pkg::WORD_W-1:0]  rdata_i,
  output eep_pkg::store_req_t         store_req_o,
  output eep_pkg::out_item_t          res_o
);

  eep_pkg::mode_e mode_q, mode_d;
  logic [6:0]     bc_q, bc_d;
  logic [3:0]     bi_q, bi_d;
  logic [13:0]    addr_q, addr_d;
  logic           in_use_q, in_use_d;
  logic           large_q, large_d;
  logic [7:0]     sb_q [8];
  logic [7:0]     sb_d [8];
  logic           rd_bit;
  logic           stored;

  // next state for one accepted item
  always_comb begin
    logic [6:0] bc_inc;
    logic       bit_in;
    logic       large_dma;
    logic       enter;
    mode_d    = mode_q;
    bc_d      = bc_q;
    bi_d      = bi_q;
    addr_d    = addr_q;
    in_use_d  = in_use_q;
    large_d   = large_q;
    sb_d      = sb_q;
    rd_bit    = 1'b0;
    stored    = 1'b0;
    enter     = 1'b0;
    bc_inc    = bc_q + 7'd1;
    bit_in    = item_i.write_bit;
    large_dma = (item_i.dma_count == eep_pkg::DMA_LARGE_A) ||
                (item_i.dma_count == eep_pkg::DMA_LARGE_B);

    if (acc_i) begin
      if (!item_i.op) begin
        // bit read
        case (mode_q)
          eep_pkg::MODE_RDPRE: begin
            bc_d = bc_inc;
            if (bc_inc == eep_pkg::CNT_RDPRE_END) begin
              mode_d = eep_pkg::MODE_RDDATA;
              bc_d   = '0;
              bi_d   = '0;
            end
          end
          eep_pkg::MODE_RDDATA: begin
            rd_bit = rdata_i[~bc_q[5:0]];
            bc_d   = bc_inc;
            if (bc_inc[2:0] == 3'd0 && bi_q < eep_pkg::BYTE_IDX_MAX) begin
              bi_d = bi_q + 4'd1;
            end
            if (bc_inc == eep_pkg::CNT_BLOCK) begin
              mode_d = eep_pkg::MODE_IDLE;
            end
          end
          default: begin
            rd_bit = 1'b1;
          end
        endcase
      end else if (item_i.dma_count != 16'd0) begin
        // bit write
        case (mode_q)
          eep_pkg::MODE_IDLE: begin
            bi_d     = '0;
            bc_d     = 7'd1;
            sb_d[0]  = {7'd0, bit_in};
            mode_d   = eep_pkg::MODE_ADDR;
          end
          eep_pkg::MODE_RDPRE, eep_pkg::MODE_RDDATA: begin
            mode_d = eep_pkg::MODE_IDLE;
          end
          eep_pkg::MODE_ADDR, eep_pkg::MODE_WRDATA: begin
            // shift into the current byte; once the byte index reaches its cap, bits are dropped
            if (bi_q < eep_pkg::BYTE_IDX_MAX) begin
              sb_d[bi_q[2:0]] = {sb_q[bi_q[2:0]][6:0], bit_in};
            end
            bc_d = bc_inc;
            if (bc_inc[2:0] == 3'd0 && bi_q < eep_pkg::BYTE_IDX_MAX) begin
              bi_d = bi_q + 4'd1;
            end
            if (mode_q == eep_pkg::MODE_ADDR) begin
              // address phase end
              if (large_dma) begin
                if (bc_inc == eep_pkg::CNT_ADDR_LARGE) begin
                  in_use_d = 1'b1;
                  large_d  = 1'b1;
                  addr_d   = {sb_d[0][5:0], sb_d[1]};
                  enter    = 1'b1;
                end
              end else if (bc_inc == eep_pkg::CNT_ADDR_SMALL) begin
                in_use_d = 1'b1;
                addr_d   = {8'd0, sb_d[0][5:0]};
                enter    = 1'b1;
              end
              if (enter) begin
                bi_d = '0;
                if ((sb_d[0] & eep_pkg::CMD_READ_BIT) == 8'd0) begin
                  sb_d[0] = {7'd0, bit_in};
                  bc_d    = 7'd1;
                  mode_d  = eep_pkg::MODE_WRDATA;
                end else begin
                  bc_d   = '0;
                  mode_d = eep_pkg::MODE_RDPRE;
                end
              end
            end else begin
              // data phase: store the block, then take the stop bit
              if (bc_inc == eep_pkg::CNT_BLOCK) begin
                in_use_d = 1'b1;
                stored   = 1'b1;
              end else if (bc_inc == eep_pkg::CNT_STOP) begin
                mode_d = eep_pkg::MODE_IDLE;
                bi_d   = '0;
                bc_d   = '0;
              end
            end
          end
          default: begin
            mode_d = eep_pkg::MODE_IDLE;
          end
        endcase
      end
    end
  end

  // store access: write on a completed block, read follows the address
  assign store_req_o.we    = stored;
  assign store_req_o.idx   = addr_q[eep_pkg::IDX_W-1:0];
  assign store_req_o.wdata = {sb_d[0], sb_d[1], sb_d[2], sb_d[3],
                              sb_d[4], sb_d[5], sb_d[6], sb_d[7]};

  // result of the item
  assign res_o.read_bit      = rd_bit;
  assign res_o.block_written = stored;
  assign res_o.in_use        = in_use_d;
  assign res_o.large_size    = large_d;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= eep_pkg::MODE_IDLE;
      bc_q     <= '0;
      bi_q     <= '0;
      addr_q   <= '0;
      in_use_q <= 1'b0;
      large_q  <= 1'b0;
    end else begin
      mode_q   <= mode_d;
      bc_q     <= bc_d;
      bi_q     <= bi_d;
      addr_q   <= addr_d;
      in_use_q <= in_use_d;
      large_q  <= large_d;
    end
  end

  // shift bytes, payload only
  always_ff @(posedge clk_i) begin
    sb_q <= sb_d;
  end

  // the registered read word must belong to the address in use
  `EEP_ASSERT(a_rddata_addr_stable, clk_i, rst_ni, (mode_q == eep_pkg::MODE_RDDATA) |-> $stable(addr_q))
  // byte index never runs past the overflow byte
  `EEP_ASSERT(a_byte_idx_cap, clk_i, rst_ni, bi_q <= eep_pkg::BYTE_IDX_MAX)
  // a stored block always comes with the in-use flag set afterwards
  `EEP_ASSERT(a_store_sets_in_use, clk_i, rst_ni, store_req_o.we |=> in_use_q)

endmodule

/* hw/rtl/eep_skid.sv */
// two-entry output buffer between the sequencer and the result channel
// depends on eep_pkg and assert_macros.svh
`include "assert_macros.svh"

module eep_skid (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  eep_pkg::out_item_t in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output eep_pkg::out_item_t out_item_o
);

  logic               out_v_q, out_v_d;
  logic               skid_v_q, skid_v_d;
  eep_pkg::out_item_t out_q, out_d;
  eep_pkg::out_item_t skid_q, skid_d;
  logic               push;
  logic               pop;

  assign in_ready_o = !skid_v_q;
  assign push       = in_valid_i && !skid_v_q;
  assign pop        = out_v_q && out_ready_i;

  // buffer steering
  always_comb begin
    out_v_d  = out_v_q;
    skid_v_d = skid_v_q;
    out_d    = out_q;
    skid_d   = skid_q;
    if (push) begin
      if (out_v_q && !out_ready_i) begin
        skid_d   = in_item_i;
        skid_v_d = 1'b1;
      end else begin
        out_d   = in_item_i;
        out_v_d = 1'b1;
      end
    end else if (pop) begin
      if (skid_v_q) begin
        out_d    = skid_q;
        skid_v_d = 1'b0;
      end else begin
        out_v_d = 1'b0;
      end
    end
  end

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

  // the skid entry only fills behind a held output entry
  `EEP_ASSERT_ALWAYS(a_skid_behind_out, clk_i, skid_v_q |-> out_v_q)

endmodule

/* test/serial_eeprom_bit_protocol_tb.sv */
// testbench for the serial eeprom bit protocol block: random bus accesses with a
// bit-exact prediction of every result item; needs eep_pkg and the block's rtl
`timescale 1ns / 100ps

module serial_eeprom_bit_protocol_tb;

  localparam int ITEM_GOAL      = 1850;
  localparam int STALL_LIMIT    = 500;
  localparam int DRAIN_CYCLES   = 8;
  localparam int DMA_KIND_SMALL = 0;
  localparam int DMA_KIND_LARGE = 1;
  localparam int DMA_KIND_ANY   = 2;
  localparam int FULL_READ      = 68;

  // eeprom behaviour tracked per accepted item, results queued for comparison
  class eeprom_scoreboard;
    eep_pkg::mode_e     mode;
    logic [6:0]         bit_cnt;
    logic [3:0]         byte_idx;
    logic [13:0]        blk_addr;
    logic [7:0]         shreg [9];
    logic               in_use_q;
    logic               wide_q;
    logic [63:0]        store [eep_pkg::BLOCK_COUNT];
    bit                 written [eep_pkg::BLOCK_COUNT];
    eep_pkg::out_item_t awaited_q [$];
    int                 errors;
    int                 n_results;
    int                 n_stores;
    int                 n_data_reads;

    function new();
      mode     = eep_pkg::MODE_IDLE;
      bit_cnt  = '0;
      byte_idx = '0;
      blk_addr = '0;
      in_use_q = 1'b0;
      wide_q   = 1'b0;
      foreach (shreg[i]) shreg[i] = '0;
      foreach (store[i]) begin
        store[i]   = '0;
        written[i] = 1'b0;
      end
      errors       = 0;
      n_results    = 0;
      n_stores     = 0;
      n_data_reads = 0;
    endfunction

    function int pending();
      return awaited_q.size();
    endfunction

    // one serial bit into the buffer, last byte keeps taking bits once full
    function void shift_bit(logic b);
      int i;
      i = (byte_idx > eep_pkg::BYTE_IDX_MAX) ? int'(eep_pkg::BYTE_IDX_MAX) : int'(byte_idx);
      shreg[i] = {shreg[i][6:0], b};
      bit_cnt  = bit_cnt + 7'd1;
      if (bit_cnt[2:0] == 3'd0 && byte_idx < eep_pkg::BYTE_IDX_MAX)
        byte_idx = byte_idx + 4'd1;
    endfunction

    // address complete: command bit picks write data or read preamble
    function void enter_data(logic b);
      if ((shreg[0] & eep_pkg::CMD_READ_BIT) == 8'h00) begin
        shreg[0] = {7'd0, b};
        bit_cnt  = 7'd1;
        byte_idx = 4'd0;
        mode     = eep_pkg::MODE_WRDATA;
      end else begin
        bit_cnt  = 7'd0;
        byte_idx = 4'd0;
        mode     = eep_pkg::MODE_RDPRE;
      end
    endfunction

    function void note_access(eep_pkg::in_item_t it);
      eep_pkg::out_item_t r;
      logic [63:0]        word;
      logic [5:0]         pos;
      int unsigned        idx;
      r   = '0;
      idx = blk_addr % eep_pkg::BLOCK_COUNT;
      if (it.op == 1'b0) begin
        case (mode)
          eep_pkg::MODE_RDPRE: begin
            bit_cnt = bit_cnt + 7'd1;
            if (bit_cnt == eep_pkg::CNT_RDPRE_END) begin
              mode     = eep_pkg::MODE_RDDATA;
              bit_cnt  = 7'd0;
              byte_idx = 4'd0;
            end
          end
          eep_pkg::MODE_RDDATA: begin
            word       = store[idx];
            pos        = 6'd63 - {byte_idx[2:0], bit_cnt[2:0]};
            r.read_bit = word[pos];
            bit_cnt    = bit_cnt + 7'd1;
            if (bit_cnt[2:0] == 3'd0 && byte_idx < eep_pkg::BYTE_IDX_MAX)
              byte_idx = byte_idx + 4'd1;
            if (bit_cnt == eep_pkg::CNT_BLOCK) mode = eep_pkg::MODE_IDLE;
            n_data_reads++;
          end
          default: r.read_bit = 1'b1;
        endcase
      end else if (it.dma_count != 16'h0000) begin
        case (mode)
          eep_pkg::MODE_IDLE: begin
            byte_idx = 4'd0;
            bit_cnt  = 7'd1;
            shreg[0] = {7'd0, it.write_bit};
            mode     = eep_pkg::MODE_ADDR;
          end
          eep_pkg::MODE_ADDR: begin
            shift_bit(it.write_bit);
            if (it.dma_count == eep_pkg::DMA_LARGE_A ||
                it.dma_count == eep_pkg::DMA_LARGE_B) begin
              if (bit_cnt == eep_pkg::CNT_ADDR_LARGE) begin
                in_use_q = 1'b1;
                wide_q   = 1'b1;
                blk_addr = {shreg[0][5:0], shreg[1]};
                enter_data(it.write_bit);
              end
            end else if (bit_cnt == eep_pkg::CNT_ADDR_SMALL) begin
              in_use_q = 1'b1;
              blk_addr = {8'h00, shreg[0][5:0]};
              enter_data(it.write_bit);
            end
          end
          eep_pkg::MODE_RDPRE, eep_pkg::MODE_RDDATA: mode = eep_pkg::MODE_IDLE;
          default: begin
            shift_bit(it.write_bit);
            if (bit_cnt == eep_pkg::CNT_BLOCK) begin
              in_use_q       = 1'b1;
              store[idx]     = {shreg[0], shreg[1], shreg[2], shreg[3],
                                shreg[4], shreg[5], shreg[6], shreg[7]};
              written[idx]   = 1'b1;
              r.block_written = 1'b1;
              n_stores++;
            end else if (bit_cnt == eep_pkg::CNT_STOP) begin
              mode     = eep_pkg::MODE_IDLE;
              byte_idx = 4'd0;
              bit_cnt  = 7'd0;
            end
          end
        endcase
      end
      r.in_use     = in_use_q;
      r.large_size = wide_q;
      awaited_q.push_back(r);
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task compare_bit(string field, logic got, logic want);
      if (got !== want)
        report($sformatf("result %0d: %s is %b, expected %b", n_results, field, got, want));
    endtask

    task check_result(eep_pkg::out_item_t got);
      eep_pkg::out_item_t want;
      if (awaited_q.size() == 0) begin
        report($sformatf("result %0d arrived with no access waiting", n_results));
        return;
      end
      want = awaited_q.pop_front();
      compare_bit("read_bit", got.read_bit, want.read_bit);
      compare_bit("block_written", got.block_written, want.block_written);
      compare_bit("in_use", got.in_use, want.in_use);
      compare_bit("large_size", got.large_size, want.large_size);
      n_results++;
    endtask
  endclass

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  eep_pkg::in_item_t  in_item   = '0;
  logic               out_ready = 1'b0;
  logic               in_ready;
  logic               out_valid;
  eep_pkg::out_item_t out_item;

  eeprom_scoreboard sb = new();
  bit calm = 1'b0;
  int n_counted = 0;
  int idle_cycles = 0;

  serial_eeprom_bit_protocol i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // random field helpers
  function automatic logic rbit();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic logic [15:0] small_dma();
    logic [15:0] v;
    do v = 16'($urandom_range(1, 65535));
    while (v == eep_pkg::DMA_LARGE_A || v == eep_pkg::DMA_LARGE_B);
    return v;
  endfunction

  function automatic logic [15:0] dma_of(int kind);
    case (kind)
      DMA_KIND_SMALL: return small_dma();
      DMA_KIND_LARGE: return $urandom_range(0, 1) ? eep_pkg::DMA_LARGE_A : eep_pkg::DMA_LARGE_B;
      default:        return 16'($urandom_range(1, 65535));
    endcase
  endfunction

  // one bus access: random gap, hold until accepted, then predict
  task automatic send_access(logic op, logic wbit, logic [15:0] dma);
    eep_pkg::in_item_t it;
    int gap;
    it.op        = op;
    it.write_bit = wbit;
    it.dma_count = dma;
    // never read data out of a block that was never stored: abort instead
    if (op == 1'b0 && sb.mode == eep_pkg::MODE_RDDATA &&
        !sb.written[sb.blk_addr % eep_pkg::BLOCK_COUNT]) begin
      it.op = 1'b1;
      if (dma == 16'h0000) it.dma_count = 16'h0001;
    end
    gap = calm ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_access(it);
    if (!(it.op && it.dma_count == 16'h0000)) n_counted++;
  endtask

  // serial write bits msb first, with harmless stray accesses mixed in
  task automatic send_bits(logic [63:0] bits, int n, int kind, bit noisy);
    for (int k = n - 1; k >= 0; k--) begin
      if (noisy && $urandom_range(0, 15) == 0) begin
        if ($urandom_range(0, 1)) send_access(1'b0, rbit(), 16'($urandom));
        else send_access(1'b1, rbit(), 16'h0000);
      end
      send_access(1'b1, bits[k], dma_of(kind));
    end
  endtask

  // keep writing bits until the protocol is back at idle
  task automatic settle();
    while (sb.mode != eep_pkg::MODE_IDLE) send_access(1'b1, rbit(), small_dma());
  endtask

  task automatic write_block(bit wide);
    logic [13:0] addr;
    logic [63:0] data;
    case ($urandom_range(0, 5))
      0:       addr = '0;
      1:       addr = '1;
      default: addr = 14'($urandom);
    endcase
    case ($urandom_range(0, 7))
      0:       data = '0;
      1:       data = '1;
      default: data = {$urandom, $urandom};
    endcase
    // the first data bit still belongs to the address phase
    if (wide) send_bits(64'({rbit(), 1'b0, addr, data[63]}), 17, DMA_KIND_LARGE, 1'b1);
    else send_bits(64'({rbit(), 1'b0, addr[5:0], data[63]}), 9, DMA_KIND_SMALL, 1'b1);
    send_bits(data, 63, DMA_KIND_ANY, 1'b1);
    send_access(1'b1, rbit(), dma_of(DMA_KIND_ANY));
  endtask

  function automatic int pick_written(bit wide);
    int lim;
    int start;
    lim   = wide ? eep_pkg::BLOCK_COUNT : 64;
    start = $urandom_range(0, lim - 1);
    for (int k = 0; k < lim; k++)
      if (sb.written[(start + k) % lim]) return (start + k) % lim;
    return -1;
  endfunction

  // read command for a stored block, full read-out or cut short by a write
  task automatic read_block(bit wide);
    int idx;
    int n_rd;
    logic [9:0] blk;
    idx = pick_written(wide);
    if (idx < 0) begin
      write_block(wide);
      return;
    end
    blk = idx[9:0];
    if (wide) begin
      send_bits(64'({rbit(), 1'b1, 4'($urandom), blk, rbit()}), 17, DMA_KIND_LARGE, 1'b1);
    end else begin
      send_bits(64'({rbit(), 1'b1, blk[5:0], rbit()}), 9, DMA_KIND_SMALL, 1'b1);
    end
    n_rd = ($urandom_range(0, 4) == 0) ? $urandom_range(0, FULL_READ - 1) : FULL_READ;
    repeat (n_rd) begin
      if ($urandom_range(0, 15) == 0) send_access(1'b1, rbit(), 16'h0000);
      send_access(1'b0, rbit(), 16'($urandom));
    end
    if (n_rd < FULL_READ) send_access(1'b1, rbit(), dma_of(DMA_KIND_ANY));
    else send_access(1'b0, rbit(), 16'($urandom));
  endtask

  // address phase that misses both lengths, so the bit counter wraps
  task automatic wrap_address();
    repeat (9) send_access(1'b1, rbit(), dma_of(DMA_KIND_LARGE));
    repeat (8) send_access(1'b1, rbit(), small_dma());
    settle();
  endtask

  // fully random accesses, dma count zero and the wide codes made likely
  task automatic junk(int n);
    logic [15:0] dma;
    repeat (n) begin
      case ($urandom_range(0, 3))
        0:       dma = 16'h0000;
        1:       dma = dma_of(DMA_KIND_LARGE);
        default: dma = 16'($urandom);
      endcase
      send_access(rbit(), rbit(), dma);
    end
  endtask

  // receiver: a fresh stall before every result item
  initial begin
    int stall;
    while (!rst_n) @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 19);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // result checking
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_item);
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // stimulus
  initial begin
    int kind;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reads outside a sequence, writes with dma count zero
    send_access(1'b0, 1'b0, 16'h0000);
    send_access(1'b0, 1'b1, 16'hFFFF);
    send_access(1'b1, 1'b1, 16'h0000);
    send_access(1'b1, 1'b0, 16'h0000);
    // read command to the top small address, abandoned in the preamble
    send_bits(64'({1'b1, 1'b1, 6'h3F, 1'b0}), 9, DMA_KIND_SMALL, 1'b0);
    send_access(1'b0, 1'b0, 16'h0001);
    send_access(1'b0, 1'b1, 16'hFFFF);
    send_access(1'b1, 1'b1, 16'hFFFF);
    send_access(1'b0, 1'b1, eep_pkg::DMA_LARGE_A);

    // random sequences, mostly well formed
    while (n_counted < ITEM_GOAL) begin
      calm = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 19);
      settle();
      if (kind < 8) write_block(rbit());
      else if (kind < 16) read_block(rbit());
      else if (kind < 18) wrap_address();
      else junk($urandom_range(1, 12));
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d accesses and %0d result items", n_counted, sb.n_results);
    $display("%0d blocks stored, %0d stored bits read back", sb.n_stores, sb.n_data_reads);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/eep_pkg.sv
hw/rtl/eep_store.sv
hw/rtl/eep_ctrl.sv
hw/rtl/eep_skid.sv
hw/rtl/serial_eeprom_bit_protocol.sv
test/serial_eeprom_bit_protocol_tb.sv
